/* hdl/cbc_pkg.sv */
package cbc_pkg;

	// sizes
	localparam int RAM_BYTES     = 131072;
	localparam int ROM_BANKS_MAX = 512;
	localparam int RAM_AW        = $clog2(RAM_BYTES);
	localparam int BANK_W        = 9;
	localparam int RAM_BANK_W    = 4;
	localparam int WIN_W         = 13;
	localparam int OFF_W         = RAM_BANK_W + WIN_W;
	localparam int LIMIT_W       = 18;
	localparam int COUNT_W       = 10;
	localparam int ROM_W         = 23;
	localparam int ROM_WIN_W     = 14;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_W         = 18;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HAS_RUMBLE     = 2'd2;

	// bus map
	localparam logic [15:0] A_ROMB_LO = 16'h2000;
	localparam logic [15:0] A_ROMB_HI = 16'h3000;
	localparam logic [15:0] A_RAMB    = 16'h4000;
	localparam logic [15:0] A_CTL_END = 16'h6000;
	localparam logic [15:0] A_BANKED  = 16'h4000;
	localparam logic [15:0] A_ROM_END = 16'h8000;
	localparam logic [15:0] A_RAM_LO  = 16'hA000;
	localparam logic [15:0] A_RAM_HI  = 16'hBFFF;

	localparam logic [3:0] RAM_EN_KEY = 4'hA;
	localparam logic [7:0] OPEN_BUS   = 8'hFF;
	localparam logic       OP_WRITE   = 1'b1;

	// mapper state seen by the access decode
	typedef struct packed {
		logic                  ram_en;
		logic [BANK_W-1:0]     rom_bank;
		logic [RAM_BANK_W-1:0] ram_bank;
		logic [BANK_W-1:0]     rom_mask;
		logic [LIMIT_W-1:0]    ram_limit;
	} cbc_state_t;

	// smallest all-ones mask covering the bank count
	function automatic logic [BANK_W-1:0] bank_mask(input logic [COUNT_W-1:0] count);
		logic [COUNT_W-1:0] banks;
		logic [COUNT_W-1:0] top;
		logic [BANK_W-1:0]  m;
		banks = (count > COUNT_W'(ROM_BANKS_MAX)) ? COUNT_W'(ROM_BANKS_MAX) : count;
		top   = (banks == '0) ? '0 : banks - COUNT_W'(1);
		for (int i = 0; i < BANK_W; i++) begin
			m[i] = |(top[BANK_W-1:0] >> i);
		end
		return m;
	endfunction

endpackage

/* hdl/cbc_ram.sv */
module cbc_ram
	import cbc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [RAM_AW-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [RAM_AW-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	output logic [7:0]        rd_data,
	output logic              busy
);

	logic [7:0]        mem [RAM_BYTES];
	logic [7:0]        rd_data_q;
	logic              clr_q;
	logic [RAM_AW-1:0] clr_addr_q;
	logic              mem_we;
	logic [RAM_AW-1:0] mem_waddr;
	logic [7:0]        mem_wdata;

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + RAM_AW'(1);
			if (clr_addr_q == RAM_AW'(RAM_BYTES - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// write port shared by the sweep and the bus
	always_comb begin
		mem_we    = clr_q | wr_en;
		mem_waddr = clr_q ? clr_addr_q : wr_addr;
		mem_wdata = clr_q ? OPEN_BUS : wr_data;
	end

	// storage and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_q;

endmodule

/* hdl/cbc_regs.sv */
module cbc_regs
	import cbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 bus_wr,
	input  logic [15:0]          bus_addr,
	input  logic [7:0]           bus_data,
	output cbc_state_t           state
);

	logic                  ram_en_q;
	logic [BANK_W-1:0]     rom_bank_q;
	logic [RAM_BANK_W-1:0] ram_bank_q;
	logic [BANK_W-1:0]     rom_mask_q;
	logic [LIMIT_W-1:0]    ram_limit_q;
	logic                  rumble_q;
	logic [LIMIT_W-1:0]    size_in;
	logic [RAM_BANK_W-1:0] ram_bank_in;

	// ram size from cfg_data (clipped to the memory on write), drop the top bank bit with rumble
	always_comb begin
		size_in     = cfg_data[LIMIT_W-1:0];
		ram_bank_in = bus_data[RAM_BANK_W-1:0];
		if (rumble_q) begin
			ram_bank_in[RAM_BANK_W-1] = 1'b0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_mask_q  <= bank_mask(COUNT_W'(ROM_BANKS_MAX));
			ram_limit_q <= '0;
			rumble_q    <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_ROM_BANK_COUNT: rom_mask_q <= bank_mask(cfg_data[COUNT_W-1:0]);
				CFG_RAM_SIZE: begin
					ram_limit_q <= (size_in > LIMIT_W'(RAM_BYTES)) ?
						LIMIT_W'(RAM_BYTES) : size_in;
				end
				CFG_HAS_RUMBLE: rumble_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// mapper control writes from the bus
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_en_q   <= 1'b0;
			rom_bank_q <= BANK_W'(1);
			ram_bank_q <= '0;
		end else if (bus_wr) begin
			if (bus_addr < A_ROMB_LO) begin
				ram_en_q <= (bus_data[3:0] == RAM_EN_KEY);
			end else if (bus_addr < A_ROMB_HI) begin
				rom_bank_q[7:0] <= bus_data;
			end else if (bus_addr < A_RAMB) begin
				rom_bank_q[BANK_W-1] <= bus_data[0];
			end else if (bus_addr < A_CTL_END) begin
				ram_bank_q <= ram_bank_in;
			end
		end
	end

	always_comb begin
		state.ram_en    = ram_en_q;
		state.rom_bank  = rom_bank_q;
		state.ram_bank  = ram_bank_q;
		state.rom_mask  = rom_mask_q;
		state.ram_limit = ram_limit_q;
	end

endmodule

/* hdl/cartridge_bank_controller.sv */
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+-----------------------------------
// in       | input     | in_valid / in_ready   | operation, address, write_data
// out      | output    | out_valid / out_ready | read_data, rom_read, rom_address
// cfg      | input     | cfg_write (no wait)   | cfg_index, cfg_data
//
// one access per cycle sustained while out is not stalled; a result is registered in the decode
// stage (RAM read at that edge), then in the output register; the registered RAM read sets this.
// after reset the RAM sweep writes 0xFF to all 131072 bytes, one per cycle, and
// in_ready stays low until the sweep ends; cfg writes are taken throughout.
// when out is stalled the decode stage holds one more access, then in_ready drops.
module cartridge_bank_controller
	import cbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [15:0]          address,
	input  logic [7:0]           write_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           read_data,
	output logic                 rom_read,
	output logic [ROM_W-1:0]     rom_address
);

	cbc_state_t        state;
	logic              ram_busy;
	logic [7:0]        ram_rdata;
	logic              in_xfer;
	logic              advance;
	logic              in_ram_win;
	logic [OFF_W-1:0]  ram_off;
	logic              ram_hit;
	logic              ram_rd_en;
	logic              ram_wr_en;
	logic              rom_hit;
	logic [ROM_W-1:0]  rom_addr_d;
	logic [BANK_W-1:0] bank_eff;

	logic              valid_s1;
	logic              ram_hit_s1;
	logic              rom_read_s1;
	logic [ROM_W-1:0]  rom_address_s1;

	logic              out_valid_q;
	logic [7:0]        read_data_q;
	logic              rom_read_q;
	logic [ROM_W-1:0]  rom_address_q;

	// handshake
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~ram_busy & (~valid_s1 | advance);
	assign in_xfer  = in_valid & in_ready;

	cbc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bus_wr    (in_xfer & (operation == OP_WRITE)),
		.bus_addr  (address),
		.bus_data  (write_data),
		.state     (state)
	);

	// access decode
	always_comb begin
		in_ram_win = (address >= A_RAM_LO) & (address <= A_RAM_HI);
		ram_off    = {state.ram_bank, address[WIN_W-1:0]};
		ram_hit    = in_ram_win & state.ram_en &
			({{(LIMIT_W-OFF_W){1'b0}}, ram_off} < state.ram_limit);
		ram_rd_en  = in_xfer & (operation != OP_WRITE) & ram_hit;
		ram_wr_en  = in_xfer & (operation == OP_WRITE) & ram_hit;
		rom_hit    = (operation != OP_WRITE) & (address < A_ROM_END);
		bank_eff   = state.rom_bank & state.rom_mask;
		if (!rom_hit) begin
			rom_addr_d = '0;
		end else if (address < A_BANKED) begin
			rom_addr_d = {{(ROM_W-16){1'b0}}, address};
		end else begin
			rom_addr_d = {bank_eff, address[ROM_WIN_W-1:0]};
		end
	end

	cbc_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_off[RAM_AW-1:0]),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_off[RAM_AW-1:0]),
		.wr_data (write_data),
		.rd_data (ram_rdata),
		.busy    (ram_busy)
	);

	// decode stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ram_hit_s1     <= ram_rd_en;
			rom_read_s1    <= rom_hit;
			rom_address_s1 <= rom_addr_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q   <= ram_hit_s1 ? ram_rdata : OPEN_BUS;
			rom_read_q    <= rom_read_s1;
			rom_address_q <= rom_address_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign rom_read    = rom_read_q;
	assign rom_address = rom_address_q;

	// a held RAM read keeps its read data
	a_rdata_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance && ram_hit_s1) |=> $stable(ram_rdata))
		else $error("ram read data changed under a held access");

	// no bus access to RAM while the sweep runs
	a_no_access_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_rd_en || ram_wr_en) |-> !ram_busy)
		else $error("ram access during clearing sweep");

	// RAM is touched only when enabled
	a_ram_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_rd_en || ram_wr_en) |-> state.ram_en)
		else $error("ram access while disabled");

	// a ROM result never carries RAM data
	a_rom_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && rom_read_s1) |-> !ram_hit_s1)
		else $error("rom and ram hit on one access");

endmodule
